[hw/rtl/sbfr_pkg.sv]
package sbfr_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int PAYLOAD_BYTES = 23;
  localparam int CHAN_BITS     = 11;
  localparam int CIDX_W        = 4;
  localparam int POS_W         = 5;
  localparam int PW_W          = 12;
  localparam int STORE_BITS    = PAYLOAD_BYTES * 8;
  localparam int BITOFS_W      = $clog2(STORE_BITS);

  localparam logic [7:0]          SYNC_FOOTER = 8'h00;
  localparam logic [7:0]          SYNC_HEADER = 8'h0F;
  localparam logic [POS_W-1:0]    POS_NONE    = 5'd31;
  localparam logic [POS_W-1:0]    POS_LAST    = POS_W'(PAYLOAD_BYTES - 1);
  localparam logic [CIDX_W-1:0]   CHAN_LAST   = CIDX_W'(NUM_CHANNELS - 1);
  localparam logic [7:0]          TIMEOUT_RST = 8'd10;

  localparam logic [PW_W-1:0]     PW_BASE     = 12'd880;
  localparam logic [CHAN_BITS:0]  RAW_FULL    = 12'd2047;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

endpackage

[hw/rtl/sbfr_chan_unit.sv]
module sbfr_chan_unit (
  input  logic [sbfr_pkg::STORE_BITS-1:0] payload,
  input  logic [sbfr_pkg::CIDX_W-1:0]     chan,
  output logic [sbfr_pkg::CHAN_BITS-1:0]  raw,
  output logic [sbfr_pkg::PW_W-1:0]       pulse
);

  logic [sbfr_pkg::BITOFS_W-1:0]    bit_ofs;
  logic [2*sbfr_pkg::CHAN_BITS-1:0] scaled;
  logic [sbfr_pkg::CHAN_BITS-1:0]   quot0;
  logic [sbfr_pkg::CHAN_BITS:0]     rem0;
  logic [sbfr_pkg::CHAN_BITS-1:0]   quot;

  // channel c starts at bit 11*c of the payload, lsb first
  assign bit_ofs = (sbfr_pkg::BITOFS_W'(chan) << 3) + (sbfr_pkg::BITOFS_W'(chan) << 1)
                 + sbfr_pkg::BITOFS_W'(chan);
  assign raw = payload[bit_ofs +: sbfr_pkg::CHAN_BITS];

  // raw * 1280
  assign scaled = ({1'b0, raw, 10'b0} + {3'b0, raw, 8'b0});

  // floor(scaled / 2047): estimate with >> 11, one correction step
  assign quot0 = scaled[2*sbfr_pkg::CHAN_BITS-1:sbfr_pkg::CHAN_BITS];
  assign rem0  = {1'b0, scaled[sbfr_pkg::CHAN_BITS-1:0]} + {1'b0, quot0};
  assign quot  = quot0 + sbfr_pkg::CHAN_BITS'(rem0 >= sbfr_pkg::RAW_FULL);

  assign pulse = sbfr_pkg::PW_BASE + sbfr_pkg::PW_W'(quot);

endmodule

[hw/rtl/sbus_frame_receiver.sv]
// channel   signals                                          direction
// in        in_valid, in_ready, req_type, rx_byte            request in
// out       out_valid, out_ready, channel_index, raw_value,  result out
//           pulse_width_us, channel17, channel18,
//           frame_lost, failsafe, last_of_frame
// cfg       cfg_valid, cfg_ready, frame_timeout_ms           register write
//
// a good footer byte starts a pass of the channel unit over the 16 channels, one result per cycle
// output stalls stretch that pass; in_ready stays low until the last result is loaded
// rst is synchronous, active high; the payload bytes have no reset
module sbus_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [7:0]                        rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sbfr_pkg::CIDX_W-1:0]       channel_index,
  output logic [sbfr_pkg::CHAN_BITS-1:0]    raw_value,
  output logic [sbfr_pkg::PW_W-1:0]         pulse_width_us,
  output logic                              channel17,
  output logic                              channel18,
  output logic                              frame_lost,
  output logic                              failsafe,
  output logic                              last_of_frame,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        frame_timeout_ms
);

  typedef enum logic [1:0] {
    PH_WAIT_ZERO = 2'd0,
    PH_WAIT_HDR  = 2'd1,
    PH_PAYLOAD   = 2'd2
  } phase_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  state_t                          state;
  phase_t                          phase, phase_next;
  logic [sbfr_pkg::POS_W-1:0]      byte_position, pos_next, pos_inc;
  logic [7:0]                      idle_ticks, ticks_next, ticks_inc;
  logic [7:0]                      timeout;
  logic [sbfr_pkg::CIDX_W-1:0]     chan_cnt;
  logic [7:0]                      payload_store [sbfr_pkg::PAYLOAD_BYTES];
  logic [sbfr_pkg::STORE_BITS-1:0] payload_vec;
  logic                            store_we;
  logic                            start_emit;
  logic                            in_fire, load_out;
  logic [sbfr_pkg::CHAN_BITS-1:0]  unit_raw;
  logic [sbfr_pkg::PW_W-1:0]       unit_pulse;
  logic [7:0]                      flag_byte;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign load_out  = (state == S_EMIT) && (!out_valid || out_ready);
  assign pos_inc   = byte_position + 1'b1;
  assign ticks_inc = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  assign flag_byte = payload_store[sbfr_pkg::PAYLOAD_BYTES-1];

  always_comb begin
    for (int i = 0; i < sbfr_pkg::PAYLOAD_BYTES; i++) begin
      payload_vec[i*8 +: 8] = payload_store[i];
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = byte_position;
    ticks_next = idle_ticks;
    store_we   = 1'b0;
    start_emit = 1'b0;
    if (req_type == sbfr_pkg::REQ_TICK) begin
      ticks_next = ticks_inc;
      if (ticks_inc > timeout) begin
        ticks_next = 8'd0;
        phase_next = PH_WAIT_ZERO;
      end
    end else begin
      ticks_next = 8'd0;
      unique case (phase)
        PH_WAIT_HDR: begin
          phase_next = (rx_byte == sbfr_pkg::SYNC_HEADER) ? PH_PAYLOAD : PH_WAIT_ZERO;
        end
        PH_PAYLOAD: begin
          pos_next = pos_inc;
          if (pos_inc <= sbfr_pkg::POS_LAST) begin
            store_we = 1'b1;
            if (pos_inc == sbfr_pkg::POS_LAST) begin
              phase_next = PH_WAIT_ZERO;
            end
          end else begin
            phase_next = PH_WAIT_ZERO;
          end
        end
        default: begin
          if (rx_byte == sbfr_pkg::SYNC_FOOTER) begin
            start_emit = (byte_position == sbfr_pkg::POS_LAST);
            phase_next = PH_WAIT_HDR;
            pos_next   = sbfr_pkg::POS_NONE;
          end
        end
      endcase
    end
  end

  sbfr_chan_unit u_chan (
    .payload (payload_vec),
    .chan    (chan_cnt),
    .raw     (unit_raw),
    .pulse   (unit_pulse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_WAIT_ZERO;
      byte_position  <= sbfr_pkg::POS_NONE;
      idle_ticks     <= 8'd0;
      timeout        <= sbfr_pkg::TIMEOUT_RST;
      chan_cnt       <= '0;
      out_valid      <= 1'b0;
      channel_index  <= '0;
      raw_value      <= '0;
      pulse_width_us <= '0;
      channel17      <= 1'b0;
      channel18      <= 1'b0;
      frame_lost     <= 1'b0;
      failsafe       <= 1'b0;
      last_of_frame  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout <= frame_timeout_ms;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            phase         <= phase_next;
            byte_position <= pos_next;
            idle_ticks    <= ticks_next;
            if (start_emit) begin
              state    <= S_EMIT;
              chan_cnt <= '0;
            end
          end
        end
        S_EMIT: begin
          if (load_out) begin
            channel_index  <= chan_cnt;
            raw_value      <= unit_raw;
            pulse_width_us <= unit_pulse;
            channel17      <= flag_byte[7];
            channel18      <= flag_byte[6];
            frame_lost     <= flag_byte[5];
            failsafe       <= flag_byte[4];
            last_of_frame  <= (chan_cnt == sbfr_pkg::CHAN_LAST);
            if (chan_cnt == sbfr_pkg::CHAN_LAST) begin
              state    <= S_IDLE;
              chan_cnt <= '0;
            end else begin
              chan_cnt <= chan_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      payload_store[pos_inc] <= rx_byte;
    end
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> chan_cnt == '0)
    else $error("channel counter not cleared outside a frame pass");

  a_payload_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> (byte_position < sbfr_pkg::POS_LAST ||
                             byte_position == sbfr_pkg::POS_NONE))
    else $error("payload phase with byte position at or past the last byte");

  a_footer_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && start_emit |=> state == S_EMIT && chan_cnt == '0 &&
                              byte_position == sbfr_pkg::POS_NONE)
    else $error("good footer did not start a frame pass");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load_out && chan_cnt == sbfr_pkg::CHAN_LAST |=> state == S_IDLE && last_of_frame)
    else $error("last channel did not close the frame pass");

endmodule
